>>> design/lc3x_pkg.sv
package lc3x_pkg;

    localparam int MEM_ADDR_BITS = 16;
    localparam logic [15:0] PC_RESET = 16'h3000;
    localparam logic [2:0]  CC_RESET = 3'b010;

    typedef enum logic [1:0] {
        ACT_EXEC  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_SETPC = 2'd3
    } t_action;

    localparam logic [3:0] OP_BR   = 4'h0;
    localparam logic [3:0] OP_ADD  = 4'h1;
    localparam logic [3:0] OP_LD   = 4'h2;
    localparam logic [3:0] OP_ST   = 4'h3;
    localparam logic [3:0] OP_JSR  = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LDR  = 4'h6;
    localparam logic [3:0] OP_STR  = 4'h7;
    localparam logic [3:0] OP_RTI  = 4'h8;
    localparam logic [3:0] OP_NOT  = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_STI  = 4'hB;
    localparam logic [3:0] OP_JMP  = 4'hC;
    localparam logic [3:0] OP_RES  = 4'hD;
    localparam logic [3:0] OP_LEA  = 4'hE;
    localparam logic [3:0] OP_TRAP = 4'hF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MEM1,
        ST_MEM2,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_item;   // capture the input item
        logic exec;        // evaluate the item, issue first memory read
        logic ind_read;    // issue second read for LDI with first read data as address
        logic finish;      // commit state and build the result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic needs_mem;   // result depends on a memory read
        logic needs_ind;   // LDI or STI: takes the second memory step
    } t_status;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        reg_written;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        logic [2:0]  cond_flags;
        logic        mem_written;
        logic [15:0] mem_address;
        logic [15:0] mem_value;
        logic        trap_taken;
        logic [7:0]  trap_vector;
        logic        illegal;
    } t_result;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] instruction;
        logic [15:0] address;
        logic [15:0] data;
    } t_item;

    function automatic logic [2:0] flags_of(input logic [15:0] v);
        if (v == 16'd0) begin
            return 3'b010;
        end
        return v[15] ? 3'b100 : 3'b001;
    endfunction

endpackage

>>> design/lc3x_if.sv
interface lc3x_in_if;
    logic            valid;
    logic            ready;
    lc3x_pkg::t_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lc3x_out_if;
    logic              valid;
    logic              ready;
    lc3x_pkg::t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/lc3_instruction_execute_top.sv
// LC-3 execute unit.
// Input channel (i_in): one item per transfer: action, instruction, address, data.
//   Actions: execute one instruction, write a memory word, read a memory word,
//   or set the PC. Output channel (o_out): exactly one result per item with the
//   PC, register write, condition flags, memory store/read, trap and illegal info.
// Path from input transfer to result: items without a memory read go from EXEC
//   to DONE, LD, LDR and read pass MEM1 on the way, and LDI and STI pass MEM1 and
//   MEM2 (LDI makes two dependent reads of the word memory, STI reads its pointer).
// Items are handled one at a time; a new item is taken in the same cycle the
//   previous result transfers.
// Reset (i_rst_n low, synchronous): register file cleared, PC = 0x3000, flags = Z.
//   The word memory is not cleared; read only words already written.
// When the receiver stalls, the result holds and no new item is taken.
module lc3_instruction_execute_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lc3x_in_if.sink       i_in,
    lc3x_out_if.source    o_out
);
    lc3x_pkg::t_cmd    cmd;
    lc3x_pkg::t_status status;

    lc3x_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lc3x_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in.payload),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_out.payload)
    );

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_item |-> i_in.ready)
        else $error("item loaded without input transfer");

    a_commit_then_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_out.valid)
        else $error("commit not followed by a valid result");

    a_no_commit_while_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !cmd.finish)
        else $error("commit while result pending");
endmodule

>>> design/lc3x_ctrl.sv
module lc3x_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  lc3x_pkg::t_status   i_status,
    output lc3x_pkg::t_cmd      o_cmd
);
    lc3x_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lc3x_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lc3x_pkg::ST_IDLE: if (i_in_valid) n_state = lc3x_pkg::ST_EXEC;
            lc3x_pkg::ST_EXEC: begin
                if (i_status.needs_mem) n_state = lc3x_pkg::ST_MEM1;
                else n_state = lc3x_pkg::ST_DONE;
            end
            lc3x_pkg::ST_MEM1: begin
                if (i_status.needs_ind) n_state = lc3x_pkg::ST_MEM2;
                else n_state = lc3x_pkg::ST_DONE;
            end
            lc3x_pkg::ST_MEM2: n_state = lc3x_pkg::ST_DONE;
            lc3x_pkg::ST_DONE: begin
                // take the next item while this result leaves
                if (i_out_ready) begin
                    n_state = i_in_valid ? lc3x_pkg::ST_EXEC : lc3x_pkg::ST_IDLE;
                end
            end
            default: n_state = lc3x_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            lc3x_pkg::ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.load_item   = i_in_valid;
            end
            lc3x_pkg::ST_EXEC: o_cmd.exec = 1'b1;
            lc3x_pkg::ST_MEM1: o_cmd.ind_read = i_status.needs_ind;
            lc3x_pkg::ST_MEM2: ;
            lc3x_pkg::ST_DONE: begin
                o_out_valid      = 1'b1;
                o_in_ready       = i_out_ready;
                o_cmd.load_item  = i_out_ready && i_in_valid;
            end
            default: ;
        endcase
        // commit happens on the edge that leaves the last work state
        o_cmd.finish = (n_state == lc3x_pkg::ST_DONE) && (r_state != lc3x_pkg::ST_DONE);
    end
endmodule

>>> design/lc3x_dp.sv
module lc3x_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lc3x_pkg::t_item     i_item,
    input  lc3x_pkg::t_cmd      i_cmd,
    output lc3x_pkg::t_status   o_status,
    output lc3x_pkg::t_result   o_result
);
    localparam int AW = lc3x_pkg::MEM_ADDR_BITS;

    logic [15:0] r_mem [2**AW];
    logic [15:0] r_rf [8];
    logic [15:0] r_pc;
    logic [2:0]  r_cc;
    lc3x_pkg::t_item   r_item;
    lc3x_pkg::t_result r_res;
    logic [15:0] r_rdata;

    // memory port: one read, one write
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    logic [15:0] ins;
    logic [3:0]  op;
    logic [2:0]  dr, sr;
    logic [15:0] pc1, ea9, src2, baseoff, sr_val, dr_val;

    assign ins     = r_item.instruction;
    assign op      = ins[15:12];
    assign dr      = ins[11:9];
    assign sr      = ins[8:6];
    assign pc1     = r_pc + 16'd1;
    assign ea9     = pc1 + {{7{ins[8]}}, ins[8:0]};
    assign sr_val  = r_rf[sr];
    assign dr_val  = r_rf[dr];
    assign src2    = ins[5] ? {{11{ins[4]}}, ins[4:0]} : r_rf[ins[2:0]];
    assign baseoff = sr_val + {{10{ins[5]}}, ins[5:0]};

    logic is_exec;
    assign is_exec = (r_item.action == lc3x_pkg::ACT_EXEC);

    always_comb begin
        o_status.needs_mem = 1'b0;
        o_status.needs_ind = 1'b0;
        if (r_item.action == lc3x_pkg::ACT_READ) begin
            o_status.needs_mem = 1'b1;
        end else if (is_exec) begin
            case (op)
                lc3x_pkg::OP_LD, lc3x_pkg::OP_LDR: o_status.needs_mem = 1'b1;
                lc3x_pkg::OP_LDI, lc3x_pkg::OP_STI: begin
                    o_status.needs_mem = 1'b1;
                    o_status.needs_ind = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // read address: first read in exec, dependent read after
    always_comb begin
        mem_re    = i_cmd.exec || (i_cmd.ind_read && op == lc3x_pkg::OP_LDI);
        mem_raddr = r_item.address[AW-1:0];
        if (i_cmd.ind_read) begin
            mem_raddr = r_rdata[AW-1:0];
        end else if (is_exec) begin
            mem_raddr = (op == lc3x_pkg::OP_LDR) ? baseoff[AW-1:0] : ea9[AW-1:0];
        end
    end

    // compute the result; r_rdata holds the last read word
    lc3x_pkg::t_result res;
    logic setcc;
    always_comb begin
        res         = '0;
        setcc       = 1'b0;
        res.next_pc = r_pc;
        res.cond_flags = r_cc;
        case (r_item.action)
            lc3x_pkg::ACT_WRITE: begin
                res.mem_written = 1'b1;
                res.mem_address = r_item.address;
                res.mem_value   = r_item.data;
            end
            lc3x_pkg::ACT_READ: begin
                res.mem_address = r_item.address;
                res.mem_value   = r_rdata;
            end
            lc3x_pkg::ACT_SETPC: res.next_pc = r_item.address;
            default: begin
                res.next_pc = pc1;
                case (op)
                    lc3x_pkg::OP_BR: if ((dr & r_cc) != 3'd0) res.next_pc = ea9;
                    lc3x_pkg::OP_ADD: begin
                        res.reg_written = 1'b1; res.reg_index = dr;
                        res.reg_value = sr_val + src2; setcc = 1'b1;
                    end
                    lc3x_pkg::OP_AND: begin
                        res.reg_written = 1'b1; res.reg_index = dr;
                        res.reg_value = sr_val & src2; setcc = 1'b1;
                    end
                    lc3x_pkg::OP_NOT: begin
                        res.reg_written = 1'b1; res.reg_index = dr;
                        res.reg_value = ~sr_val; setcc = 1'b1;
                    end
                    lc3x_pkg::OP_LD, lc3x_pkg::OP_LDR, lc3x_pkg::OP_LDI: begin
                        res.reg_written = 1'b1; res.reg_index = dr;
                        res.reg_value = r_rdata; setcc = 1'b1;
                    end
                    lc3x_pkg::OP_LEA: begin
                        res.reg_written = 1'b1; res.reg_index = dr;
                        res.reg_value = ea9; setcc = 1'b1;
                    end
                    lc3x_pkg::OP_ST: begin
                        res.mem_written = 1'b1; res.mem_address = ea9;
                        res.mem_value = dr_val;
                    end
                    lc3x_pkg::OP_STR: begin
                        res.mem_written = 1'b1; res.mem_address = baseoff;
                        res.mem_value = dr_val;
                    end
                    lc3x_pkg::OP_STI: begin
                        res.mem_written = 1'b1; res.mem_address = r_rdata;
                        res.mem_value = dr_val;
                    end
                    lc3x_pkg::OP_JSR: begin
                        res.reg_written = 1'b1; res.reg_index = 3'd7;
                        res.reg_value = pc1;
                        res.next_pc = ins[11] ? pc1 + {{5{ins[10]}}, ins[10:0]} : sr_val;
                    end
                    lc3x_pkg::OP_JMP: res.next_pc = sr_val;
                    lc3x_pkg::OP_TRAP: begin
                        res.reg_written = 1'b1; res.reg_index = 3'd7;
                        res.reg_value = pc1; res.trap_taken = 1'b1;
                        res.trap_vector = ins[7:0];
                    end
                    default: res.illegal = 1'b1;
                endcase
                if (setcc) res.cond_flags = lc3x_pkg::flags_of(res.reg_value);
            end
        endcase
    end

    assign mem_we    = i_cmd.finish && res.mem_written;
    assign mem_waddr = res.mem_address[AW-1:0];
    assign mem_wdata = res.mem_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
        if (i_cmd.finish) begin
            r_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= lc3x_pkg::PC_RESET;
            r_cc <= lc3x_pkg::CC_RESET;
            for (int i = 0; i < 8; i++) r_rf[i] <= '0;
        end else if (i_cmd.finish) begin
            r_pc <= res.next_pc;
            r_cc <= res.cond_flags;
            if (res.reg_written) r_rf[res.reg_index] <= res.reg_value;
        end
    end

    assign o_result = r_res;
endmodule

>>> tb/lc3x_checker.sv
module lc3x_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lc3x_in_if    i_in,
    lc3x_out_if   i_out,
    output int    o_errors,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lc3x_pkg::*;

    logic [15:0] gpr [8];
    logic [15:0] pc;
    logic [2:0]  cc;
    logic [15:0] mem_words [logic [15:0]];
    t_result     result_q [$];

    function automatic logic [15:0] sx(input logic [15:0] v, input int bits);
        logic [15:0] m;
        m = (16'd1 << bits) - 16'd1;
        v = v & m;
        if (v[bits-1]) begin
            v = v | ~m;
        end
        return v;
    endfunction

    function automatic logic [15:0] mem_rd(input logic [15:0] a);
        return mem_words.exists(a) ? mem_words[a] : 16'd0;
    endfunction

    function automatic logic [2:0] nzp(input logic [15:0] v);
        if (v == 16'd0) begin
            return 3'b010;
        end
        return v[15] ? 3'b100 : 3'b001;
    endfunction

    // advance the shadow state by one item and return its result
    function automatic t_result execute_item(input t_item it);
        t_result     r;
        logic [3:0]  op;
        logic [2:0]  dr, sr;
        logic [15:0] npc, ea9, src2, baseoff, ins;
        logic        setcc;
        r = '0;
        setcc = 1'b0;
        ins = it.instruction;
        case (t_action'(it.action))
            ACT_WRITE: begin
                mem_words[it.address] = it.data;
                r.mem_written = 1'b1;
                r.mem_address = it.address;
                r.mem_value = it.data;
            end
            ACT_READ: begin
                r.mem_address = it.address;
                r.mem_value = mem_rd(it.address);
            end
            ACT_SETPC: pc = it.address;
            default: begin
                op = ins[15:12];
                dr = ins[11:9];
                sr = ins[8:6];
                npc = pc + 16'd1;
                ea9 = npc + sx(ins, 9);
                src2 = ins[5] ? sx(ins, 5) : gpr[ins[2:0]];
                baseoff = gpr[sr] + sx(ins, 6);
                case (op)
                    OP_BR: if ((dr & cc) != 3'b000) npc = ea9;
                    OP_ADD: begin
                        r.reg_written = 1'b1; r.reg_index = dr;
                        r.reg_value = gpr[sr] + src2; setcc = 1'b1;
                    end
                    OP_LD: begin
                        r.reg_written = 1'b1; r.reg_index = dr;
                        r.reg_value = mem_rd(ea9); setcc = 1'b1;
                    end
                    OP_ST: begin
                        r.mem_written = 1'b1; r.mem_address = ea9; r.mem_value = gpr[dr];
                    end
                    OP_JSR: begin
                        r.reg_written = 1'b1; r.reg_index = 3'd7; r.reg_value = npc;
                        npc = ins[11] ? npc + sx(ins, 11) : gpr[sr];
                    end
                    OP_AND: begin
                        r.reg_written = 1'b1; r.reg_index = dr;
                        r.reg_value = gpr[sr] & src2; setcc = 1'b1;
                    end
                    OP_LDR: begin
                        r.reg_written = 1'b1; r.reg_index = dr;
                        r.reg_value = mem_rd(baseoff); setcc = 1'b1;
                    end
                    OP_STR: begin
                        r.mem_written = 1'b1; r.mem_address = baseoff;
                        r.mem_value = gpr[dr];
                    end
                    OP_NOT: begin
                        r.reg_written = 1'b1; r.reg_index = dr;
                        r.reg_value = ~gpr[sr]; setcc = 1'b1;
                    end
                    OP_LDI: begin
                        r.reg_written = 1'b1; r.reg_index = dr;
                        r.reg_value = mem_rd(mem_rd(ea9)); setcc = 1'b1;
                    end
                    OP_STI: begin
                        r.mem_written = 1'b1; r.mem_address = mem_rd(ea9);
                        r.mem_value = gpr[dr];
                    end
                    OP_JMP: npc = gpr[sr];
                    OP_LEA: begin
                        r.reg_written = 1'b1; r.reg_index = dr;
                        r.reg_value = ea9; setcc = 1'b1;
                    end
                    OP_TRAP: begin
                        r.reg_written = 1'b1; r.reg_index = 3'd7; r.reg_value = npc;
                        r.trap_taken = 1'b1; r.trap_vector = ins[7:0];
                    end
                    default: r.illegal = 1'b1;
                endcase
                if (r.reg_written) gpr[r.reg_index] = r.reg_value;
                if (setcc) cc = nzp(r.reg_value);
                if (r.mem_written) mem_words[r.mem_address] = r.mem_value;
                pc = npc;
            end
        endcase
        r.next_pc = pc;
        r.cond_flags = cc;
        return r;
    endfunction

    function automatic string bad_fields(input t_result e, input t_result a);
        string s;
        s = "";
        if (e.next_pc !== a.next_pc) s = {s, " next_pc"};
        if (e.reg_written !== a.reg_written) s = {s, " reg_written"};
        if (e.reg_index !== a.reg_index) s = {s, " reg_index"};
        if (e.reg_value !== a.reg_value) s = {s, " reg_value"};
        if (e.cond_flags !== a.cond_flags) s = {s, " cond_flags"};
        if (e.mem_written !== a.mem_written) s = {s, " mem_written"};
        if (e.mem_address !== a.mem_address) s = {s, " mem_address"};
        if (e.mem_value !== a.mem_value) s = {s, " mem_value"};
        if (e.trap_taken !== a.trap_taken) s = {s, " trap_taken"};
        if (e.trap_vector !== a.trap_vector) s = {s, " trap_vector"};
        if (e.illegal !== a.illegal) s = {s, " illegal"};
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        string   diff;
        if (!i_rst_n) begin
            foreach (gpr[k]) gpr[k] = 16'd0;
            pc = PC_RESET;
            cc = CC_RESET;
            result_q.delete();
            o_errors = 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                result_q.push_back(execute_item(i_in.payload));
            end
            if (i_out.valid && i_out.ready) begin
                if (result_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result %h", i_out.payload);
                end else begin
                    exp_r = result_q.pop_front();
                    diff = bad_fields(exp_r, i_out.payload);
                    if (diff != "") begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("mismatch:%s exp %h got %h", diff, exp_r, i_out.payload);
                        end
                    end
                end
            end
        end
        o_pending = result_q.size();
    end

endmodule

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lc3x_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic calm;
    int   cycles;
    int   errors;
    int   pending;
    int   stall_left;
    int   sent;

    logic [15:0] written_addrs [$];
    logic [3:0]  plain_ops [12] = '{OP_BR, OP_ADD, OP_ST, OP_JSR, OP_AND, OP_STR,
                                    OP_RTI, OP_NOT, OP_JMP, OP_RES, OP_LEA, OP_TRAP};

    lc3x_in_if  in_ch ();
    lc3x_out_if out_ch ();

    lc3_instruction_execute_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lc3x_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[lc3_instruction_execute_top] ERROR");
            $finish;
        end
    end

    // result side: hold ready low in random bursts
    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    function automatic logic [15:0] sx(input logic [15:0] v, input int bits);
        logic [15:0] m;
        m = (16'd1 << bits) - 16'd1;
        v = v & m;
        if (v[bits-1]) v = v | ~m;
        return v;
    endfunction

    task automatic transfer(input t_action act, input logic [15:0] ins,
                            input logic [15:0] addr, input logic [15:0] dat);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= '{action: act, instruction: ins, address: addr, data: dat};
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent++;
    endtask

    task automatic exec(input logic [15:0] ins);
        transfer(ACT_EXEC, ins, 16'($urandom), 16'($urandom));
    endtask

    task automatic set_pc(input logic [15:0] p);
        transfer(ACT_SETPC, 16'($urandom), p, 16'($urandom));
    endtask

    task automatic store_word(input logic [15:0] a, input logic [15:0] d);
        transfer(ACT_WRITE, 16'($urandom), a, d);
        written_addrs.push_back(a);
    endtask

    task automatic fetch_word();
        transfer(ACT_READ, 16'($urandom),
                 written_addrs[$urandom_range(0, written_addrs.size() - 1)],
                 16'($urandom));
    endtask

    // loads: place the words they need first, at addresses computed from a known PC
    task automatic load_direct(input logic [15:0] ins);
        logic [15:0] p;
        p = 16'($urandom);
        set_pc(p);
        store_word(p + 16'd1 + sx(ins, 9), 16'($urandom));
        exec({OP_LD, ins[11:0]});
    endtask

    task automatic load_base(input logic [15:0] ins);
        logic [15:0] p, lea;
        p = 16'($urandom);
        lea = 16'($urandom);
        set_pc(p);
        exec({OP_LEA, ins[8:6], lea[8:0]});
        store_word(p + 16'd1 + sx(lea, 9) + sx(ins, 6), 16'($urandom));
        exec({OP_LDR, ins[11:0]});
    endtask

    task automatic indirect(input logic [3:0] op, input logic [15:0] ins);
        logic [15:0] p, ea, ptr;
        p = 16'($urandom);
        ea = p + 16'd1 + sx(ins, 9);
        do ptr = 16'($urandom); while (ptr == ea);
        set_pc(p);
        store_word(ea, ptr);
        if (op == OP_LDI) store_word(ptr, 16'($urandom));
        exec({op, ins[11:0]});
    endtask

    task automatic plain_op(input logic [3:0] op);
        logic [15:0] r;
        r = 16'($urandom);
        exec({op, r[11:0]});
    endtask

    // any instruction word; route memory reads through setup of their words
    task automatic random_exec(input logic [15:0] ins);
        case (ins[15:12])
            OP_LD: load_direct(ins);
            OP_LDR: load_base(ins);
            OP_LDI, OP_STI: indirect(ins[15:12], ins);
            default: exec(ins);
        endcase
    endtask

    initial begin
        int pick;
        rst_n = 1'b0;
        calm = 1'b0;
        cycles = 0;
        sent = 0;
        stall_left = 0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and every opcode
        store_word(16'h0000, 16'h0000);
        store_word(16'hFFFF, 16'hFFFF);
        fetch_word();
        set_pc(16'hFFFF);
        exec({OP_ADD, 3'd1, 3'd0, 1'b1, 5'h0F});
        exec({OP_ADD, 3'd2, 3'd1, 1'b1, 5'h10});
        exec({OP_ADD, 3'd3, 3'd1, 1'b0, 2'b00, 3'd2});
        exec({OP_AND, 3'd4, 3'd2, 1'b1, 5'h1F});
        exec({OP_NOT, 3'd5, 3'd4, 6'h3F});
        exec({OP_BR, 3'b000, 9'h1FF});
        exec({OP_BR, 3'b111, 9'h100});
        exec({OP_JSR, 1'b1, 11'h7FF});
        exec({OP_JSR, 1'b0, 2'b00, 3'd7, 6'h00});
        exec({OP_JMP, 3'd0, 3'd7, 6'h00});
        exec({OP_LEA, 3'd6, 9'h0FF});
        exec({OP_TRAP, 4'h0, 8'hFF});
        exec({OP_RTI, 12'hFFF});
        exec({OP_RES, 12'h000});
        exec({OP_ST, 3'd5, 9'h1FF});
        exec({OP_STR, 3'd2, 3'd3, 6'h20});
        load_direct({4'h0, 3'd7, 9'h100});
        load_base({4'h0, 3'd0, 3'd5, 6'h1F});
        indirect(OP_LDI, {4'h0, 3'd3, 9'h0FF});
        indirect(OP_STI, {4'h0, 3'd1, 9'h1FF});

        // random mix; the last stretch runs without idling
        while (sent < 470) begin
            if (sent > 400) calm = 1'b1;
            pick = $urandom_range(0, 19);
            if (pick < 9) plain_op(plain_ops[$urandom_range(0, 11)]);
            else if (pick == 9) load_direct(16'($urandom));
            else if (pick == 10) load_base(16'($urandom));
            else if (pick == 11) indirect(OP_LDI, 16'($urandom));
            else if (pick == 12) indirect(OP_STI, 16'($urandom));
            else if (pick == 13) store_word(16'($urandom), 16'($urandom));
            else if (pick == 14) fetch_word();
            else if (pick == 15) set_pc(16'($urandom));
            else random_exec(16'($urandom));
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0) begin
            $display("[lc3_instruction_execute_top] OK");
        end else begin
            $display("[lc3_instruction_execute_top] ERROR");
        end
        $finish;
    end

endmodule
